// ----- hw/rtl/multi_pattern_rolling_hash_matcher_core_assert.svh -----
// Assertion macros shared by the matcher's checker.
// Each macro expands to one labeled concurrent assertion.
`ifndef MULTI_PATTERN_ROLLING_HASH_MATCHER_CORE_ASSERT_SVH
`define MULTI_PATTERN_ROLLING_HASH_MATCHER_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define MPRHM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matcher assertion failed");

// The consequent holds in the cycle after the antecedent.
`define MPRHM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matcher assertion failed");

`endif

// ----- hw/rtl/mprhm_pkg.sv -----
// Shared types and constants of the rolling hash matcher.
// No dependencies.
`default_nettype none
package mprhm_pkg;

  localparam int unsigned MUL_W = 16;
  localparam int unsigned POS_W = 16;
  localparam int unsigned LEN_OUT_W = 6;

  typedef enum logic [1:0] {
    OP_PATTERN = 2'd0,
    OP_TEXT    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_SLOTS_FULL = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mprhm_mulmod.sv -----
// Bit-serial modular multiply-add: res = (a * b + z) mod HASH_MODULUS.
// One multiplier bit per cycle, then a final step adds the addend. Uses mprhm_pkg.
`default_nettype none
module mprhm_mulmod import mprhm_pkg::*; #(
  parameter int unsigned HASH_MODULUS = 1000003,
  parameter int unsigned HW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [HW-1:0] a,
  input  wire logic [MUL_W-1:0] b,
  input  wire logic [HW-1:0] z,
  output logic               done,
  output logic [HW-1:0]      res
);

  localparam int unsigned CW = $clog2(MUL_W + 1);
  localparam logic [HW:0] MOD = (HW + 1)'(HASH_MODULUS);

  logic [HW-1:0] acc;
  logic [HW-1:0] a_q;
  logic [HW-1:0] z_q;
  logic [MUL_W-1:0] b_q;
  logic [CW-1:0] cnt;
  logic busy;

  logic [HW:0] dbl, red1, sum, red2, fin, finr;

  always_comb begin
    dbl  = {acc, 1'b0};
    red1 = (dbl >= MOD) ? dbl - MOD : dbl;
    sum  = red1 + (b_q[MUL_W-1] ? {1'b0, a_q} : '0);
    red2 = (sum >= MOD) ? sum - MOD : sum;
    fin  = {1'b0, acc} + {1'b0, z_q};
    finr = (fin >= MOD) ? fin - MOD : fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= '0;
        a_q  <= a;
        b_q  <= b;
        z_q  <= z;
        cnt  <= CW'(MUL_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != '0) begin
          acc <= red2[HW-1:0];
          b_q <= b_q << 1;
          cnt <= cnt - 1'b1;
        end else begin
          acc  <= finr[HW-1:0];
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = acc;

endmodule
`default_nettype wire

// ----- hw/rtl/multi_pattern_rolling_hash_matcher_core.sv -----
// Multi-pattern rolling hash matcher: one item at a time through a shared mulmod unit.
// A clear or unused op loads the result register directly; a text byte runs, per slot, a
// subtract once the window is full, a hash update and, while unmatched and enough bytes are seen,
// a pattern table scan. A pattern byte updates power (not on the first byte) and hash, or only
// flags overflow; a last byte adds a table scan and a window rehash for a new length. The next
// item is taken in the cycle after the result loads. Synchronous active-high reset.
`default_nettype none
module multi_pattern_rolling_hash_matcher_core import mprhm_pkg::*; #(
  parameter int unsigned HASH_BASE = 256,
  parameter int unsigned HASH_MODULUS = 1000003,
  parameter int unsigned MAX_PATTERN_LENGTH = 32,
  parameter int unsigned MAX_LENGTH_SLOTS = 4,
  parameter int unsigned MAX_PATTERNS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  byte_value,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             match,
  output logic [15:0]      start_position,
  output logic [5:0]       match_length,
  output logic [1:0]       status
);

  localparam int unsigned HW  = $clog2(HASH_MODULUS);
  localparam int unsigned LW  = $clog2(MAX_PATTERN_LENGTH + 1);
  localparam int unsigned IW  = (MAX_PATTERN_LENGTH > 1) ? $clog2(MAX_PATTERN_LENGTH) : 1;
  localparam int unsigned SW  = (MAX_LENGTH_SLOTS > 1) ? $clog2(MAX_LENGTH_SLOTS) : 1;
  localparam int unsigned SCW = $clog2(MAX_LENGTH_SLOTS + 1);
  localparam int unsigned PW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned PCW = $clog2(MAX_PATTERNS + 1);
  localparam logic [HW:0] MOD = (HW + 1)'(HASH_MODULUS);
  localparam logic [MUL_W-1:0] BASE = MUL_W'(HASH_BASE);
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_PSTART = 18'h00002,
    S_PCM    = 18'h00004,
    S_PPOW   = 18'h00008,
    S_PHASH  = 18'h00010,
    S_COMMIT = 18'h00020,
    S_CSCAN  = 18'h00040,
    S_CDEC   = 18'h00080,
    S_WLOOP  = 18'h00100,
    S_WCM    = 18'h00200,
    S_WHASH  = 18'h00400,
    S_TCM    = 18'h00800,
    S_TSLOT  = 18'h01000,
    S_TSUB   = 18'h02000,
    S_THASH  = 18'h04000,
    S_TSCAN  = 18'h08000,
    S_TEND   = 18'h10000,
    S_DONE   = 18'h20000
  } state_t;

  state_t state;

  logic case_fold;
  logic [7:0]    window [MAX_PATTERN_LENGTH];
  logic [HW-1:0] slot_hash [MAX_LENGTH_SLOTS];
  logic [LW-1:0] slot_length [MAX_LENGTH_SLOTS];
  logic [HW-1:0] slot_power [MAX_LENGTH_SLOTS];
  logic [SCW-1:0] slot_count;
  logic [HW-1:0] pattern_table [MAX_PATTERNS];
  logic [PCW-1:0] pattern_count;
  logic [HW-1:0] load_hash;
  logic [LW-1:0] load_length;
  logic [HW-1:0] load_power;
  logic load_ovf;
  logic [POS_W-1:0] text_position;

  logic [7:0] cur_byte;
  logic cur_last;
  logic [HW-1:0] cm;
  logic [HW-1:0] acc_h;
  logic [SCW-1:0] si;
  logic [PCW-1:0] sidx;
  logic [IW-1:0] widx;
  logic [LW-1:0] wcnt;
  logic found;
  logic hash_new;
  logic r_match;
  logic [POS_W-1:0] r_start;
  logic [LEN_OUT_W-1:0] r_len;
  logic [1:0] r_status;
  logic mm_issued;

  logic mm_start, mm_done;
  logic [HW-1:0] mm_a, mm_z, mm_res;
  logic [MUL_W-1:0] mm_b;

  logic [POS_W:0] seen;
  logic [LW-1:0] cur_len;
  logic seen_le, seen_ge;
  logic [7:0] win_rd;
  logic [HW-1:0] tab_rd;
  logic len_found;
  logic [HW:0] sub_wrap;
  logic [LW-1:0] wmin;
  logic [7:0] folded;
  logic [POS_W-1:0] start_calc;
  logic compute;

  always_comb begin
    seen     = {1'b0, text_position} + 1'b1;
    cur_len  = slot_length[si[SW-1:0]];
    seen_le  = seen <= (POS_W + 1)'(cur_len);
    seen_ge  = seen >= (POS_W + 1)'(cur_len);
    win_rd   = window[widx];
    tab_rd   = pattern_table[sidx[PW-1:0]];
    sub_wrap = ({1'b0, acc_h} >= {1'b0, mm_res}) ? {1'b0, acc_h} - {1'b0, mm_res}
                                                 : {1'b0, acc_h} + MOD - {1'b0, mm_res};
    wmin     = (text_position < POS_W'(load_length)) ? LW'(text_position) : load_length;
    folded   = (case_fold && byte_value >= 8'h41 && byte_value <= 8'h5A)
               ? byte_value + 8'h20 : byte_value;
    start_calc = (text_position == POS_MAX) ? POS_MAX : seen[POS_W-1:0] - POS_W'(cur_len);
    len_found = 1'b0;
    for (int i = 0; i < MAX_LENGTH_SLOTS; i++) begin
      if (SCW'(i) < slot_count && slot_length[i] == load_length) begin
        len_found = 1'b1;
      end
    end
  end

  always_comb begin
    compute = 1'b1;
    mm_a = '0;
    mm_b = '0;
    mm_z = '0;
    case (state)
      S_PCM, S_TCM: begin
        mm_a = HW'(1);
        mm_b = MUL_W'(cur_byte);
      end
      S_WCM: begin
        mm_a = HW'(1);
        mm_b = MUL_W'(win_rd);
      end
      S_PPOW: begin
        mm_a = load_power;
        mm_b = BASE;
      end
      S_PHASH: begin
        mm_a = load_hash;
        mm_b = BASE;
        mm_z = cm;
      end
      S_WHASH, S_THASH: begin
        mm_a = acc_h;
        mm_b = BASE;
        mm_z = cm;
      end
      S_TSUB: begin
        mm_a = slot_power[si[SW-1:0]];
        mm_b = MUL_W'(win_rd);
      end
      default: compute = 1'b0;
    endcase
    mm_start = compute && !mm_issued;
  end

  mprhm_mulmod #(
    .HASH_MODULUS(HASH_MODULUS),
    .HW(HW)
  ) u_mulmod (
    .clk(clk),
    .rst(rst),
    .start(mm_start),
    .a(mm_a),
    .b(mm_b),
    .z(mm_z),
    .done(mm_done),
    .res(mm_res)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      case_fold     <= 1'b0;
      slot_count    <= '0;
      pattern_count <= '0;
      load_hash     <= '0;
      load_length   <= '0;
      load_power    <= HW'(1);
      load_ovf      <= 1'b0;
      text_position <= '0;
      out_valid     <= 1'b0;
      mm_issued     <= 1'b0;
      for (int i = 0; i < MAX_PATTERN_LENGTH; i++) begin
        window[i] <= '0;
      end
      for (int i = 0; i < MAX_LENGTH_SLOTS; i++) begin
        slot_hash[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case_fold <= cfg_data;
      end
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (mm_done) begin
        mm_issued <= 1'b0;
      end else if (mm_start) begin
        mm_issued <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_last <= last;
            r_match  <= 1'b0;
            r_start  <= '0;
            r_len    <= '0;
            r_status <= ST_OK;
            case (op)
              OP_PATTERN: begin
                cur_byte <= byte_value;
                state    <= S_PSTART;
              end
              OP_TEXT: begin
                cur_byte <= folded;
                state    <= S_TCM;
              end
              OP_CLEAR: begin
                for (int i = 0; i < MAX_LENGTH_SLOTS; i++) begin
                  slot_hash[i] <= '0;
                end
                slot_count    <= '0;
                pattern_count <= '0;
                load_hash     <= '0;
                load_length   <= '0;
                load_power    <= HW'(1);
                load_ovf      <= 1'b0;
                state         <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_PSTART: begin
          if (load_ovf || load_length >= LW'(MAX_PATTERN_LENGTH)) begin
            load_ovf <= 1'b1;
            r_status <= ST_TOO_LONG;
            state    <= cur_last ? S_COMMIT : S_DONE;
          end else begin
            state <= S_PCM;
          end
        end

        S_PCM: begin
          if (mm_done) begin
            cm    <= mm_res;
            state <= (load_length != '0) ? S_PPOW : S_PHASH;
          end
        end

        S_PPOW: begin
          if (mm_done) begin
            load_power <= mm_res;
            state      <= S_PHASH;
          end
        end

        S_PHASH: begin
          if (mm_done) begin
            load_hash   <= mm_res;
            load_length <= load_length + 1'b1;
            state       <= cur_last ? S_COMMIT : S_DONE;
          end
        end

        S_COMMIT: begin
          if (load_ovf || load_length == '0) begin
            r_status    <= load_ovf ? ST_TOO_LONG : ST_OK;
            load_hash   <= '0;
            load_length <= '0;
            load_power  <= HW'(1);
            load_ovf    <= 1'b0;
            state       <= S_DONE;
          end else begin
            sidx  <= '0;
            state <= S_CSCAN;
          end
        end

        S_CSCAN: begin
          if (sidx == pattern_count) begin
            hash_new <= 1'b1;
            state    <= S_CDEC;
          end else if (tab_rd == load_hash) begin
            hash_new <= 1'b0;
            state    <= S_CDEC;
          end else begin
            sidx <= sidx + 1'b1;
          end
        end

        S_CDEC: begin
          if ((hash_new && pattern_count >= PCW'(MAX_PATTERNS)) ||
              (!len_found && slot_count >= SCW'(MAX_LENGTH_SLOTS))) begin
            r_status    <= (hash_new && pattern_count >= PCW'(MAX_PATTERNS))
                           ? ST_TABLE_FULL : ST_SLOTS_FULL;
            load_hash   <= '0;
            load_length <= '0;
            load_power  <= HW'(1);
            load_ovf    <= 1'b0;
            state       <= S_DONE;
          end else begin
            if (hash_new) begin
              pattern_table[pattern_count[PW-1:0]] <= load_hash;
              pattern_count <= pattern_count + 1'b1;
            end
            if (!len_found) begin
              slot_length[slot_count[SW-1:0]] <= load_length;
              slot_power[slot_count[SW-1:0]]  <= load_power;
              acc_h <= '0;
              wcnt  <= wmin;
              state <= S_WLOOP;
            end else begin
              load_hash   <= '0;
              load_length <= '0;
              load_power  <= HW'(1);
              load_ovf    <= 1'b0;
              state       <= S_DONE;
            end
          end
        end

        S_WLOOP: begin
          if (wcnt == '0) begin
            slot_hash[slot_count[SW-1:0]] <= acc_h;
            slot_count  <= slot_count + 1'b1;
            load_hash   <= '0;
            load_length <= '0;
            load_power  <= HW'(1);
            load_ovf    <= 1'b0;
            state       <= S_DONE;
          end else begin
            widx  <= IW'(wcnt - 1'b1);
            state <= S_WCM;
          end
        end

        S_WCM: begin
          if (mm_done) begin
            cm    <= mm_res;
            state <= S_WHASH;
          end
        end

        S_WHASH: begin
          if (mm_done) begin
            acc_h <= mm_res;
            wcnt  <= wcnt - 1'b1;
            state <= S_WLOOP;
          end
        end

        S_TCM: begin
          if (mm_done) begin
            cm    <= mm_res;
            si    <= '0;
            found <= 1'b0;
            state <= S_TSLOT;
          end
        end

        S_TSLOT: begin
          if (si == slot_count) begin
            state <= S_TEND;
          end else begin
            acc_h <= slot_hash[si[SW-1:0]];
            widx  <= IW'(cur_len - 1'b1);
            state <= seen_le ? S_THASH : S_TSUB;
          end
        end

        S_TSUB: begin
          if (mm_done) begin
            acc_h <= sub_wrap[HW-1:0];
            state <= S_THASH;
          end
        end

        S_THASH: begin
          if (mm_done) begin
            acc_h <= mm_res;
            slot_hash[si[SW-1:0]] <= mm_res;
            if (!found && seen_ge) begin
              sidx  <= '0;
              state <= S_TSCAN;
            end else begin
              si    <= si + 1'b1;
              state <= S_TSLOT;
            end
          end
        end

        S_TSCAN: begin
          if (sidx == pattern_count) begin
            si    <= si + 1'b1;
            state <= S_TSLOT;
          end else if (tab_rd == acc_h) begin
            found   <= 1'b1;
            r_match <= 1'b1;
            r_start <= start_calc;
            r_len   <= LEN_OUT_W'(cur_len);
            si      <= si + 1'b1;
            state   <= S_TSLOT;
          end else begin
            sidx <= sidx + 1'b1;
          end
        end

        S_TEND: begin
          if (cur_last) begin
            for (int i = 0; i < MAX_PATTERN_LENGTH; i++) begin
              window[i] <= '0;
            end
            for (int i = 0; i < MAX_LENGTH_SLOTS; i++) begin
              slot_hash[i] <= '0;
            end
            text_position <= '0;
          end else begin
            window[0] <= cur_byte;
            for (int i = 1; i < MAX_PATTERN_LENGTH; i++) begin
              window[i] <= window[i-1];
            end
            if (text_position != POS_MAX) begin
              text_position <= text_position + 1'b1;
            end
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            match          <= r_match;
            start_position <= r_start;
            match_length   <= r_len;
            status         <= r_status;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mprhm_checker.sv -----
// Port-level checker for the matcher, attached to the top level by bind.
// Uses mprhm_pkg and the matcher assertion macros.
`default_nettype none
`include "multi_pattern_rolling_hash_matcher_core_assert.svh"
module mprhm_checker import mprhm_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        match,
  input wire logic [15:0] start_position,
  input wire logic [5:0]  match_length,
  input wire logic [1:0]  status
);

  `MPRHM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `MPRHM_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && !in_stall, in_stall)
  `MPRHM_ASSERT_SAME(a_nomatch_zero, clk, rst, out_valid && !match, match_length == 6'd0 && start_position == 16'd0)
  `MPRHM_ASSERT_SAME(a_match_ok, clk, rst, out_valid && match, status == ST_OK && match_length != 6'd0)

endmodule

bind multi_pattern_rolling_hash_matcher_core mprhm_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .match(match),
  .start_position(start_position),
  .match_length(match_length),
  .status(status)
);
`default_nettype wire
